[rtl/core/mgsf_pkg.sv]
// Package for the motion glitch and smoothing filter.
// Holds the sequencer states, divider status, widths and register indexes.
// Used by mgsf_div and motion_glitch_and_smoothing_filter_unit.
`default_nettype none

package mgsf_pkg;

  localparam int Q8_ONE     = 256;
  localparam int SAMPLE_W   = 16;
  localparam int ALPHA_W    = 9;
  localparam int LIMIT_W    = 16;
  localparam int SMOOTH_W   = 25;
  localparam int REM_W      = 9;
  localparam int DIV_NUM_W  = 24;
  localparam int DIV_DEN_W  = 16;
  localparam int DIV_CNT_W  = 5;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_REST_GAIN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT = 4'd1;

  localparam logic [ALPHA_W-1:0] REST_GAIN_RESET   = 9'd64;
  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RESET = 16'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPEED,
    ST_SPD_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_AX_DIFF,
    ST_AX_MUL,
    ST_AX_UPD,
    ST_AX_REM,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[rtl/core/mgsf_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Uses mgsf_pkg for widths and the status struct.
`default_nettype none

module mgsf_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [mgsf_pkg::DIV_NUM_W-1:0]    num,
  input  wire logic [mgsf_pkg::DIV_DEN_W-1:0]    den,
  output logic      [mgsf_pkg::DIV_NUM_W-1:0]    quot,
  output mgsf_pkg::div_stat_t                    stat
);

  logic [mgsf_pkg::DIV_CNT_W-1:0] count_r, count_nxt;
  logic                           done_r, done_nxt;
  logic [mgsf_pkg::DIV_NUM_W-1:0] q_r, q_nxt;
  logic [mgsf_pkg::DIV_DEN_W:0]   rem_r, rem_nxt;
  logic [mgsf_pkg::DIV_DEN_W:0]   rem_sh;
  logic                           ge;

  assign rem_sh = {rem_r[mgsf_pkg::DIV_DEN_W-1:0], q_r[mgsf_pkg::DIV_NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_comb begin
    count_nxt = count_r;
    q_nxt     = q_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    if (start) begin
      count_nxt = mgsf_pkg::DIV_CNT_W'(mgsf_pkg::DIV_NUM_W);
      q_nxt     = num;
      rem_nxt   = '0;
    end else if (count_r != '0) begin
      count_nxt = count_r - 1'b1;
      q_nxt     = {q_r[mgsf_pkg::DIV_NUM_W-2:0], ge};
      rem_nxt   = ge ? rem_sh - {1'b0, den} : rem_sh;
      done_nxt  = (count_r == mgsf_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      done_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      done_r  <= done_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign quot      = q_r;
  assign stat.busy = (count_r != '0);
  assign stat.done = done_r;

endmodule

`default_nettype wire

[rtl/core/motion_glitch_and_smoothing_filter_unit.sv]
// Motion glitch suppressor and adaptive Q8 exponential smoother, top level.
// After an item is accepted, the sequencer clamps the speed, runs the 24-step serial
// divider for the gain and smooths each axis; a zero speed_limit skips the divider, rest_gain >= 256 the smoother.
// The input is ready only while the sequencer is idle, so no new item is taken until
// the last one has gone to the output register, which waits while out_tready is low.
// Synchronous active-low reset restores rest_gain = 64, speed_limit = 64; needs mgsf_pkg, mgsf_div.
`default_nettype none

module motion_glitch_and_smoothing_filter_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [31:0]                         in_tdata,   // sample_dx, sample_dy
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [31:0]                         out_tdata,  // out_dx, out_dy
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [mgsf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mgsf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  mgsf_pkg::state_t state_r, state_nxt;

  logic [mgsf_pkg::ALPHA_W-1:0]  rest_gain_r;
  logic [mgsf_pkg::LIMIT_W-1:0]  speed_limit_r;

  logic signed [15:0] held_x_r, held_y_r;
  logic               before_moved_r;
  logic signed [24:0] smooth_x_r, smooth_y_r;
  logic signed [8:0]  rem_x_r, rem_y_r;

  logic signed [15:0] gx_r, gy_r, ox_r, oy_r;
  logic [15:0]        v_r;
  logic [8:0]         alpha_r;
  logic signed [36:0] prod_r;
  logic signed [25:0] diff_r;
  logic signed [24:0] s_r;
  logic               axis_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;

  logic accept, out_free;
  logic signed [15:0] dx, dy, gx, gy;
  logic now_moved, held_moved;

  assign accept   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign dx = in_tdata[15:0];
  assign dy = in_tdata[31:16];

  // Glitch stage: a lone moving sample between two still ones is dropped.
  assign now_moved  = (dx != '0) || (dy != '0);
  assign held_moved = (held_x_r != '0) || (held_y_r != '0);
  assign gx = (held_moved && !before_moved_r && !now_moved) ? '0 : held_x_r;
  assign gy = (held_moved && !before_moved_r && !now_moved) ? '0 : held_y_r;

  // Speed, clamped to the limit.
  logic [16:0] mag_x, mag_y, speed_sum;
  assign mag_x     = gx_r[15] ? 17'(-{gx_r[15], gx_r}) : {1'b0, gx_r};
  assign mag_y     = gy_r[15] ? 17'(-{gy_r[15], gy_r}) : {1'b0, gy_r};
  assign speed_sum = mag_x + mag_y;

  // Shared multiplier.
  logic               mul_sel_spd;
  logic signed [26:0] mul_a;
  logic signed [9:0]  mul_b;
  logic signed [36:0] mul_p;
  logic [8:0]         gain_span;

  assign gain_span = 9'(mgsf_pkg::Q8_ONE) - rest_gain_r;
  assign mul_a = mul_sel_spd ? $signed({11'b0, v_r}) : $signed({diff_r[25], diff_r});
  assign mul_b = mul_sel_spd ? $signed({1'b0, gain_span}) : $signed({1'b0, alpha_r});
  assign mul_p = mul_a * mul_b;

  // Divider.
  logic                                div_start;
  logic [mgsf_pkg::DIV_NUM_W-1:0]      div_quot;
  mgsf_pkg::div_stat_t                 div_stat;

  mgsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (prod_r[mgsf_pkg::DIV_NUM_W-1:0]),
    .den   (speed_limit_r),
    .quot  (div_quot),
    .stat  (div_stat)
  );

  // Per-axis smoother arithmetic.
  logic signed [15:0] ax_d;
  logic signed [24:0] ax_sm;
  logic signed [8:0]  ax_rem;
  logic signed [25:0] diff_v;
  logic signed [36:0] prod_adj;
  logic signed [28:0] t_v, s_v;
  logic signed [25:0] r_v, r_adj, rem_v;
  logic signed [17:0] whole_v;

  assign ax_d   = axis_r ? gy_r : gx_r;
  assign ax_sm  = axis_r ? smooth_y_r : smooth_x_r;
  assign ax_rem = axis_r ? rem_y_r : rem_x_r;

  assign diff_v   = $signed({{2{ax_d[15]}}, ax_d, 8'b0}) - $signed({ax_sm[24], ax_sm});
  assign prod_adj = prod_r + (prod_r[36] ? 37'sd255 : 37'sd0);
  assign t_v      = prod_adj[36:8];
  assign s_v      = $signed({{4{ax_sm[24]}}, ax_sm}) + t_v;
  assign r_v      = $signed({{17{ax_rem[8]}}, ax_rem}) + $signed({s_r[24], s_r});
  assign r_adj    = r_v + (r_v[25] ? 26'sd255 : 26'sd0);
  assign whole_v  = r_adj[25:8];
  assign rem_v    = r_v - $signed({whole_v, 8'b0});

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mgsf_pkg::ST_IDLE: begin
        if (accept) begin
          if (rest_gain_r[8]) begin
            state_nxt = mgsf_pkg::ST_OUT;
          end else if (speed_limit_r == '0) begin
            state_nxt = mgsf_pkg::ST_AX_DIFF;
          end else begin
            state_nxt = mgsf_pkg::ST_SPEED;
          end
        end
      end
      mgsf_pkg::ST_SPEED:    state_nxt = mgsf_pkg::ST_SPD_MUL;
      mgsf_pkg::ST_SPD_MUL:  state_nxt = mgsf_pkg::ST_DIV_GO;
      mgsf_pkg::ST_DIV_GO:   state_nxt = mgsf_pkg::ST_DIV_WAIT;
      mgsf_pkg::ST_DIV_WAIT: begin
        if (div_stat.done) begin
          state_nxt = mgsf_pkg::ST_AX_DIFF;
        end
      end
      mgsf_pkg::ST_AX_DIFF:  state_nxt = mgsf_pkg::ST_AX_MUL;
      mgsf_pkg::ST_AX_MUL:   state_nxt = mgsf_pkg::ST_AX_UPD;
      mgsf_pkg::ST_AX_UPD:   state_nxt = mgsf_pkg::ST_AX_REM;
      mgsf_pkg::ST_AX_REM:   state_nxt = axis_r ? mgsf_pkg::ST_OUT : mgsf_pkg::ST_AX_DIFF;
      mgsf_pkg::ST_OUT: begin
        if (out_free) begin
          state_nxt = mgsf_pkg::ST_IDLE;
        end
      end
      default:               state_nxt = mgsf_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_tready   = 1'b0;
    div_start   = 1'b0;
    mul_sel_spd = 1'b0;
    unique case (state_r)
      mgsf_pkg::ST_IDLE:    in_tready   = 1'b1;
      mgsf_pkg::ST_SPD_MUL: mul_sel_spd = 1'b1;
      mgsf_pkg::ST_DIV_GO:  div_start   = 1'b1;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= mgsf_pkg::ST_IDLE;
      rest_gain_r    <= mgsf_pkg::REST_GAIN_RESET;
      speed_limit_r  <= mgsf_pkg::SPEED_LIMIT_RESET;
      held_x_r       <= '0;
      held_y_r       <= '0;
      before_moved_r <= 1'b0;
      smooth_x_r     <= '0;
      smooth_y_r     <= '0;
      rem_x_r        <= '0;
      rem_y_r        <= '0;
      axis_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == mgsf_pkg::CFG_REST_GAIN) begin
          rest_gain_r <= cfg_data[mgsf_pkg::ALPHA_W-1:0];
        end else if (cfg_index == mgsf_pkg::CFG_SPEED_LIMIT) begin
          speed_limit_r <= cfg_data[mgsf_pkg::LIMIT_W-1:0];
        end
      end
      if (state_r == mgsf_pkg::ST_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        mgsf_pkg::ST_IDLE: begin
          if (accept) begin
            held_x_r       <= dx;
            held_y_r       <= dy;
            before_moved_r <= held_moved;
            axis_r         <= 1'b0;
          end
        end
        mgsf_pkg::ST_AX_UPD: begin
          if (axis_r) begin
            smooth_y_r <= s_v[24:0];
          end else begin
            smooth_x_r <= s_v[24:0];
          end
        end
        mgsf_pkg::ST_AX_REM: begin
          if (axis_r) begin
            rem_y_r <= rem_v[8:0];
          end else begin
            rem_x_r <= rem_v[8:0];
          end
          axis_r <= 1'b1;
        end
        default: begin
          axis_r <= axis_r;
        end
      endcase
    end

    unique case (state_r)
      mgsf_pkg::ST_IDLE: begin
        gx_r    <= gx;
        gy_r    <= gy;
        ox_r    <= gx;
        oy_r    <= gy;
        alpha_r <= 9'(mgsf_pkg::Q8_ONE);
      end
      mgsf_pkg::ST_SPEED: begin
        v_r <= (speed_sum > {1'b0, speed_limit_r}) ? speed_limit_r : speed_sum[15:0];
      end
      mgsf_pkg::ST_SPD_MUL: prod_r <= mul_p;
      mgsf_pkg::ST_DIV_WAIT: begin
        alpha_r <= rest_gain_r + div_quot[8:0];
      end
      mgsf_pkg::ST_AX_DIFF: diff_r <= diff_v;
      mgsf_pkg::ST_AX_MUL:  prod_r <= mul_p;
      mgsf_pkg::ST_AX_UPD:  s_r    <= s_v[24:0];
      mgsf_pkg::ST_AX_REM: begin
        if (axis_r) begin
          oy_r <= whole_v[15:0];
        end else begin
          ox_r <= whole_v[15:0];
        end
      end
      mgsf_pkg::ST_OUT: begin
        if (out_free) begin
          out_data_r <= {oy_r, ox_r};
        end
      end
      default: begin
        v_r <= v_r;
      end
    endcase
  end

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("input accepted while an item is in flight");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == mgsf_pkg::ST_DIV_WAIT)
    else $error("divider finished outside its wait state");

  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == mgsf_pkg::ST_AX_DIFF |-> alpha_r <= 9'(mgsf_pkg::Q8_ONE))
    else $error("smoothing gain above unity");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for motion_glitch_and_smoothing_filter_unit.
// It drives motion samples and register writes with random pacing on both sides, and checks
// every filtered sample against a model of the glitch stage and Q8 smoother or a set value.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_ITEMS = 160;
  localparam int NUM_PHASES = 8;
  localparam logic [mgsf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 4'd15;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    logic [mgsf_pkg::CFG_IDX_W-1:0] idx;
    logic [mgsf_pkg::CFG_DATA_W-1:0] data;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic known;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
  } row_t;

  typedef struct packed {
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } motion_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;  // sample_dx, sample_dy
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;  // out_dx, out_dy
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mgsf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [mgsf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Expectation override that travels with the item on the input.
  logic drv_known = 1'b0;
  logic signed [15:0] drv_ex = '0;
  logic signed [15:0] drv_ey = '0;

  // Model state.
  logic [mgsf_pkg::ALPHA_W-1:0] gain_floor;
  logic [mgsf_pkg::LIMIT_W-1:0] speed_cap;
  logic signed [15:0] held_x, held_y;
  logic prev_moving;
  int smooth_x, smooth_y, frac_x, frac_y;

  motion_t expected_motion[$];
  int errors = 0;
  int cycles = 0;
  int results_seen = 0;
  int stall_left = 0;
  logic long_hold_done = 1'b0;
  logic no_idle = 1'b0;
  int pace_draw;

  row_t directed_rows[27];

  motion_glitch_and_smoothing_filter_unit uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic logic signed [15:0] smooth_axis(input int d, input int gain,
                                                    inout int level, inout int frac);
    longint diff, level_new, acc, whole;
    diff = longint'(d) * mgsf_pkg::Q8_ONE - level;
    level_new = level + (diff * gain) / mgsf_pkg::Q8_ONE;
    acc = frac + level_new;
    whole = acc / mgsf_pkg::Q8_ONE;
    level = int'(level_new);
    frac = int'(acc - whole * mgsf_pkg::Q8_ONE);
    return whole[15:0];
  endfunction

  function automatic void predict_filtered_motion(input logic signed [15:0] dx, dy,
                                                  output logic signed [15:0] ox, oy);
    logic signed [15:0] gx, gy;
    logic held_moving, now_moving;
    int speed, gain;
    held_moving = (held_x != 0) || (held_y != 0);
    now_moving = (dx != 0) || (dy != 0);
    gx = held_x;
    gy = held_y;
    if (held_moving && !prev_moving && !now_moving) begin
      gx = 0;
      gy = 0;
    end
    held_x = dx;
    held_y = dy;
    prev_moving = held_moving;
    ox = gx;
    oy = gy;
    if (int'(gain_floor) < mgsf_pkg::Q8_ONE) begin
      if (speed_cap == 0) begin
        gain = mgsf_pkg::Q8_ONE;
      end else begin
        speed = (gx < 0 ? -int'(gx) : int'(gx)) + (gy < 0 ? -int'(gy) : int'(gy));
        if (speed > int'(speed_cap)) speed = int'(speed_cap);
        gain = int'(gain_floor) +
               ((mgsf_pkg::Q8_ONE - int'(gain_floor)) * speed) / int'(speed_cap);
      end
      ox = smooth_axis(gx, gain, smooth_x, frac_x);
      oy = smooth_axis(gy, gain, smooth_y, frac_y);
    end
  endfunction

  function automatic logic signed [15:0] draw_axis();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return 16'sd0;
    if (r < 60) return 16'(int'($urandom_range(0, 128)) - 64);
    if (r < 82) return 16'(int'($urandom_range(0, 4000)) - 2000);
    if (r < 95) return 16'($urandom());
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return -16'sd1;
      default: return 16'sd1;
    endcase
  endfunction

  function automatic int sender_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input items are predicted and output items checked at the rising edge.
  always @(posedge clk) begin
    logic signed [15:0] px, py;
    motion_t got, want;
    if (rst_n) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        if (cfg_valid && cfg_ready) begin
          case (cfg_index)
            mgsf_pkg::CFG_REST_GAIN: gain_floor = cfg_data[mgsf_pkg::ALPHA_W-1:0];
            mgsf_pkg::CFG_SPEED_LIMIT: speed_cap = cfg_data;
            default: ;
          endcase
        end
        if (out_tvalid && out_tready) begin
          results_seen++;
          got = out_tdata;
          if (expected_motion.size() == 0) begin
            errors++;
            $error("unexpected item: out_dx %0d, out_dy %0d", got.dy, got.dx);
          end else begin
            want = expected_motion.pop_front();
            // motion_t puts dx in the upper half, the bus puts it in the lower half.
            if (got.dy !== want.dx) begin
              errors++;
              $error("out_dx: expected %0d, actual %0d", want.dx, got.dy);
            end
            if (got.dx !== want.dy) begin
              errors++;
              $error("out_dy: expected %0d, actual %0d", want.dy, got.dx);
            end
          end
        end
        if (in_tvalid && in_tready) begin
          predict_filtered_motion(in_tdata[15:0], in_tdata[31:16], px, py);
          if (drv_known) expected_motion.push_back({drv_ex, drv_ey});
          else expected_motion.push_back({px, py});
        end
      end
    end
  end

  // Result side pacing, including one long hold while the sender keeps offering items.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!long_hold_done && results_seen >= 200) begin
      out_tready <= 1'b0;
      stall_left <= LONG_HOLD - 1;
      long_hold_done <= 1'b1;
    end else begin
      out_tready <= 1'b1;
      if (!no_idle) begin
        pace_draw = $urandom_range(0, 99);
        if (pace_draw < 20) stall_left <= $urandom_range(1, 3);
        else if (pace_draw < 22) stall_left <= $urandom_range(20, 80);
      end
    end
  end

  task automatic pause_sender(input int n);
    if (n > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    while (expected_motion.size() != 0) @(negedge clk);
  endtask

  task automatic send_motion(input logic signed [15:0] dx, dy, input logic known,
                             input logic signed [15:0] ex, ey);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {dy, dx};
    drv_known <= known;
    drv_ex <= ex;
    drv_ey <= ey;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [mgsf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [mgsf_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic signed [15:0] dx, dy;
    logic [mgsf_pkg::CFG_DATA_W-1:0] alpha_w[NUM_PHASES];
    logic [mgsf_pkg::CFG_DATA_W-1:0] limit_w[NUM_PHASES];

    gain_floor = mgsf_pkg::REST_GAIN_RESET;
    speed_cap = mgsf_pkg::SPEED_LIMIT_RESET;
    held_x = 0;
    held_y = 0;
    prev_moving = 1'b0;
    smooth_x = 0;
    smooth_y = 0;
    frac_x = 0;
    frac_y = 0;

    // Reset settings first, then smoothing off, then a zero speed limit.
    directed_rows = '{
      '{ROW_ITEM, '0, '0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd32767, 16'sd32767, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, -16'sd32768, -16'sd32768, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, -16'sd32768, -16'sd32768, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, -16'sd32768, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd0, 16'sd1, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd100, -16'sd100, 1'b0, 16'sd0, 16'sd0},
      '{ROW_CFG, mgsf_pkg::CFG_REST_GAIN, 16'd256, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd7, -16'sd9, 1'b1, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, -16'sd32768, 16'sd32767, 1'b1, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd32767, -16'sd32768, 1'b1, -16'sd32768, 16'sd32767},
      '{ROW_ITEM, '0, '0, 16'sd1, 16'sd0, 1'b1, 16'sd32767, -16'sd32768},
      '{ROW_ITEM, '0, '0, 16'sd0, 16'sd0, 1'b1, 16'sd1, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0},
      '{ROW_CFG, mgsf_pkg::CFG_SPEED_LIMIT, 16'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_CFG, mgsf_pkg::CFG_REST_GAIN, 16'd0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd5, 16'sd5, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, -16'sd300, 16'sd20, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, -16'sd1, -16'sd1, 1'b0, 16'sd0, 16'sd0},
      '{ROW_ITEM, '0, '0, 16'sd0, 16'sd0, 1'b0, 16'sd0, 16'sd0}
    };

    // Upper data bits above the rest gain field are ignored by the register.
    alpha_w = '{16'd0, 16'd255, 16'd256, 16'hFE80, 16'hFFFF, 16'd0, 16'd200,
                16'($urandom_range(0, 300))};
    limit_w = '{16'd1, 16'd65535, 16'd64, 16'd0, 16'd500, 16'd65535, 16'd3,
                16'($urandom_range(1, 65535))};

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        pause_sender(1);
        wait_drained();
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        pause_sender(sender_gap());
        send_motion(directed_rows[i].dx, directed_rows[i].dy, directed_rows[i].known,
                    directed_rows[i].ex, directed_rows[i].ey);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      pause_sender(1);
      wait_drained();
      if (p == 0) write_reg(CFG_UNUSED, 16'hFFFF);
      write_reg(mgsf_pkg::CFG_REST_GAIN, alpha_w[p]);
      write_reg(mgsf_pkg::CFG_SPEED_LIMIT, limit_w[p]);
      no_idle = (p == 2);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == PHASE_ITEMS / 2) begin
          pause_sender(1);
          wait_drained();
        end
        if ($urandom_range(0, 99) < 35) begin
          dx = 0;
          dy = 0;
        end else begin
          dx = draw_axis();
          dy = draw_axis();
        end
        pause_sender(sender_gap());
        send_motion(dx, dy, 1'b0, 16'sd0, 16'sd0);
      end
    end
    no_idle = 1'b0;

    pause_sender(1);
    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/mgsf_pkg.sv
rtl/core/mgsf_div.sv
rtl/core/motion_glitch_and_smoothing_filter_unit.sv
dv/testbench.sv
